/* sv/sqlist_pkg.sv */
// Shared types and constants for the sequential list block.
// No dependencies; used by every module under sv/.
package sqlist_pkg;

  // operation codes carried in tuser
  localparam logic [1:0] KIND_FIND   = 2'd0;
  localparam logic [1:0] KIND_INSERT = 2'd1;
  localparam logic [1:0] KIND_DELETE = 2'd2;

  // result status codes
  localparam logic [2:0] STAT_OK       = 3'd0;
  localparam logic [2:0] STAT_FULL     = 3'd1;
  localparam logic [2:0] STAT_BADPOS   = 3'd2;
  localparam logic [2:0] STAT_EMPTY    = 3'd3;
  localparam logic [2:0] STAT_NOTFOUND = 3'd4;

  // field widths on the stream ports
  localparam int IN_VALUE_W = 32;
  localparam int POS_W      = 8;
  localparam int KIND_W     = 2;
  localparam int STATUS_W   = 3;
  localparam int FIDX_W     = 7;
  localparam int ECNT_W     = 8;

  // match encoder group size
  localparam int GRP   = 16;
  localparam int GRP_W = 4;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic ins;
    logic del;
    logic find;
  } cell_ctl_t;

endpackage

/* sv/sequential_list_insert_delete_find_top.sv */
// Sequential list: ordered list of signed values with insert, delete and find.
// Insert and delete pass through the EXEC and OUT states; find adds the ENC state.
// One operation at a time: a new transaction is taken only in the idle state, once the
// previous result is in the output register; the cell row shifts in EXEC, find adds one encoder stage.
// Reset (rst, synchronous) empties the list; entry contents stay undefined.
// Depends on sqlist_pkg, sqlist_cell, sqlist_enc.
module sequential_list_insert_delete_find_top #(
  parameter int CAPACITY    = 128,
  parameter int VALUE_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // value[31:0], position[39:32]
  input  logic [1:0]  s_tuser,   // kind[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata    // status[2:0], found_index[9:3], element_count[17:10]
);

  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > sqlist_pkg::POS_W) ? CW : sqlist_pkg::POS_W;
  localparam int NG   = (CAPACITY + sqlist_pkg::GRP - 1) / sqlist_pkg::GRP;
  localparam int IXW  = $clog2(NG * sqlist_pkg::GRP);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_ENC  = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0]                        state;
  logic [1:0]                        op_kind;
  logic [VALUE_WIDTH-1:0]            op_value;
  logic [sqlist_pkg::POS_W-1:0]      op_pos;
  logic [CW-1:0]                     count;
  logic [sqlist_pkg::STATUS_W-1:0]   res_status;
  logic [sqlist_pkg::STATUS_W-1:0]   status_next;

  logic                              s_fire;
  logic                              out_free;
  logic [63:0]                       value64;
  logic [CMPW-1:0]                   pos_ext;
  logic [CMPW-1:0]                   cnt_ext;
  logic                              ins_ok;
  logic                              del_ok;
  sqlist_pkg::cell_ctl_t             ctl;

  logic [VALUE_WIDTH-1:0]            cell_data [CAPACITY];
  logic [NG*sqlist_pkg::GRP-1:0]     match_vec;
  logic [NG-1:0]                     grp_any;
  logic [NG*sqlist_pkg::GRP_W-1:0]   grp_off;
  logic                              found_any;
  logic [IXW-1:0]                    idx_full;
  logic [63:0]                       idx64;
  logic [15:0]                       cnt16;
  logic [sqlist_pkg::STATUS_W-1:0]   out_status;
  logic [sqlist_pkg::FIDX_W-1:0]     out_idx;

  assign s_tready = (state == S_IDLE);
  assign s_fire   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  // sign-extend the 32-bit input, then keep VALUE_WIDTH bits
  assign value64 = {{32{s_tdata[31]}}, s_tdata[31:0]};

  // capture the transaction
  always_ff @(posedge clk) begin
    if (s_fire) begin
      op_kind  <= s_tuser;
      op_value <= value64[VALUE_WIDTH-1:0];
      op_pos   <= s_tdata[39:32];
    end
  end

  // validity checks against the current count
  assign pos_ext = CMPW'(op_pos);
  assign cnt_ext = CMPW'(count);
  assign ins_ok  = (count < CW'(CAPACITY)) && (pos_ext <= cnt_ext);
  assign del_ok  = (count != '0) && (pos_ext < cnt_ext);

  always_comb begin
    case (op_kind)
      sqlist_pkg::KIND_FIND:   status_next = sqlist_pkg::STAT_NOTFOUND;
      sqlist_pkg::KIND_INSERT: status_next = (count >= CW'(CAPACITY)) ? sqlist_pkg::STAT_FULL :
                                             ins_ok ? sqlist_pkg::STAT_OK :
                                             sqlist_pkg::STAT_BADPOS;
      sqlist_pkg::KIND_DELETE: status_next = (count == '0) ? sqlist_pkg::STAT_EMPTY :
                                             del_ok ? sqlist_pkg::STAT_OK :
                                             sqlist_pkg::STAT_BADPOS;
      default:                 status_next = sqlist_pkg::STAT_OK;
    endcase
  end

  // command broadcast to the cell row
  assign ctl.ins  = (state == S_EXEC) && (op_kind == sqlist_pkg::KIND_INSERT) && ins_ok;
  assign ctl.del  = (state == S_EXEC) && (op_kind == sqlist_pkg::KIND_DELETE) && del_ok;
  assign ctl.find = (state == S_EXEC) && (op_kind == sqlist_pkg::KIND_FIND);

  // cell row
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [VALUE_WIDTH-1:0] left;
    logic [VALUE_WIDTH-1:0] right;
    if (i == 0) begin : g_first
      assign left = op_value;
    end else begin : g_inner_l
      assign left = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right = cell_data[i];
    end else begin : g_inner_r
      assign right = cell_data[i+1];
    end
    sqlist_cell #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .IDX         (i),
      .CMPW        (CMPW)
    ) u_cell (
      .clk   (clk),
      .ctl   (ctl),
      .pos   (pos_ext),
      .count (cnt_ext),
      .value (op_value),
      .left  (left),
      .right (right),
      .data  (cell_data[i]),
      .match (match_vec[i])
    );
  end

  if (NG * sqlist_pkg::GRP > CAPACITY) begin : g_pad
    assign match_vec[NG*sqlist_pkg::GRP-1:CAPACITY] = '0;
  end

  // first level of the first-match search
  sqlist_enc #(
    .NG (NG)
  ) u_enc (
    .clk       (clk),
    .match_vec (match_vec),
    .grp_any   (grp_any),
    .grp_off   (grp_off)
  );

  // second level: lowest group with a hit
  always_comb begin
    found_any = 1'b0;
    idx_full  = '0;
    for (int g = NG - 1; g >= 0; g--) begin
      if (grp_any[g]) begin
        found_any = 1'b1;
        idx_full  = IXW'(g * sqlist_pkg::GRP) +
                    IXW'(grp_off[g*sqlist_pkg::GRP_W +: sqlist_pkg::GRP_W]);
      end
    end
  end

  assign idx64 = 64'(idx_full);
  assign cnt16 = 16'(count);

  always_comb begin
    if (op_kind == sqlist_pkg::KIND_FIND) begin
      out_status = found_any ? sqlist_pkg::STAT_OK : sqlist_pkg::STAT_NOTFOUND;
      out_idx    = found_any ? idx64[sqlist_pkg::FIDX_W-1:0] : '0;
    end else begin
      out_status = res_status;
      out_idx    = '0;
    end
  end

  // sequencer and count
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (s_fire) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (ctl.ins) begin
            count <= count + CW'(1);
          end else if (ctl.del) begin
            count <= count - CW'(1);
          end
          state <= ctl.find ? S_ENC : S_OUT;
        end
        S_ENC: begin
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EXEC) begin
      res_status <= status_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == S_OUT && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && out_free) begin
      m_tdata <= {6'b0, cnt16[sqlist_pkg::ECNT_W-1:0], out_idx, out_status};
    end
  end

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("count above capacity");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    ctl.ins |=> count == $past(count) + CW'(1))
    else $error("insert did not grow count");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && !out_free) |=> state == S_OUT)
    else $error("result dropped while output busy");

  a_found_in_list: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && op_kind == sqlist_pkg::KIND_FIND && found_any) |->
      (CMPW'(idx_full) < cnt_ext))
    else $error("found index outside list");

endmodule

/* sv/sqlist_cell.sv */
// One list entry: holds a value, shifts with its neighbors, compares for find.
// Depends on sqlist_pkg.
module sqlist_cell #(
  parameter int VALUE_WIDTH = 32,
  parameter int IDX         = 0,
  parameter int CMPW        = 8
) (
  input  logic                       clk,
  input  sqlist_pkg::cell_ctl_t      ctl,
  input  logic [CMPW-1:0]            pos,
  input  logic [CMPW-1:0]            count,
  input  logic [VALUE_WIDTH-1:0]     value,
  input  logic [VALUE_WIDTH-1:0]     left,
  input  logic [VALUE_WIDTH-1:0]     right,
  output logic [VALUE_WIDTH-1:0]     data,
  output logic                       match
);

  localparam logic [CMPW-1:0] MY_IDX = CMPW'(IDX);

  logic above_pos;
  logic at_pos;
  logic in_list;

  assign above_pos = MY_IDX > pos;
  assign at_pos    = MY_IDX == pos;
  assign in_list   = MY_IDX < count;

  // entry storage: insert opens a gap at pos, delete closes it
  always_ff @(posedge clk) begin
    if (ctl.ins) begin
      if (above_pos) begin
        data <= left;
      end else if (at_pos) begin
        data <= value;
      end
    end else if (ctl.del) begin
      if (above_pos || at_pos) begin
        data <= right;
      end
    end
  end

  // match flag, only for live entries
  always_ff @(posedge clk) begin
    if (ctl.find) begin
      match <= in_list && (data == value);
    end
  end

endmodule

/* sv/sqlist_enc.sv */
// First-match encoder, first level: one registered offset per group of cells.
// Depends on sqlist_pkg.
module sqlist_enc #(
  parameter int NG = 8
) (
  input  logic                                   clk,
  input  logic [NG*sqlist_pkg::GRP-1:0]          match_vec,
  output logic [NG-1:0]                          grp_any,
  output logic [NG*sqlist_pkg::GRP_W-1:0]        grp_off
);

  logic [NG-1:0]                     any_next;
  logic [NG*sqlist_pkg::GRP_W-1:0]   off_next;

  // lowest set bit inside each group
  always_comb begin
    any_next = '0;
    off_next = '0;
    for (int g = 0; g < NG; g++) begin
      for (int b = sqlist_pkg::GRP - 1; b >= 0; b--) begin
        if (match_vec[g*sqlist_pkg::GRP + b]) begin
          any_next[g] = 1'b1;
          off_next[g*sqlist_pkg::GRP_W +: sqlist_pkg::GRP_W] = sqlist_pkg::GRP_W'(b);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    grp_any <= any_next;
    grp_off <= off_next;
  end

endmodule

/* tb/sequential_list_insert_delete_find_top_test.sv */
// Testbench for the sequential list block: insert, delete and find through stream ports.
// A shadow list in a small scoreboard class predicts each reply and checks it field by field.
// Depends on sqlist_pkg and sequential_list_insert_delete_find_top.
`timescale 1ns / 100ps

module sequential_list_insert_delete_find_top_test;

  localparam int LIST_DEPTH = 128;
  localparam int VAL_W      = 32;

  // unused operation code: block must leave the list alone and answer ok
  localparam logic [1:0] KIND_SPARE = 2'd3;

  // one expected reply, fields as they sit in m_tdata
  typedef struct {
    logic [sqlist_pkg::STATUS_W-1:0] status;
    logic [sqlist_pkg::FIDX_W-1:0]   found_index;
    logic [sqlist_pkg::ECNT_W-1:0]   element_count;
  } list_reply_t;

  // Shadow copy of the list; predicts the reply of every accepted operation
  class list_tracker #(int DEPTH = 128);
    logic [VAL_W-1:0] entries[DEPTH];
    int               count;
    list_reply_t      replies_due[$];
    int               mismatches;

    function new();
      count      = 0;
      mismatches = 0;
    endfunction

    // apply one accepted operation and queue its reply
    function void note_op(logic [1:0] kind, logic [VAL_W-1:0] value, logic [7:0] position);
      list_reply_t r;
      int          i;
      r.status        = sqlist_pkg::STAT_OK;
      r.found_index   = '0;
      r.element_count = '0;
      case (kind)
        sqlist_pkg::KIND_FIND: begin
          r.status = sqlist_pkg::STAT_NOTFOUND;
          for (i = 0; i < count; i++) begin
            if (entries[i] == value) begin
              r.status      = sqlist_pkg::STAT_OK;
              r.found_index = i[sqlist_pkg::FIDX_W-1:0];
              break;
            end
          end
        end
        sqlist_pkg::KIND_INSERT: begin
          // full check wins over position check
          if (count >= DEPTH) begin
            r.status = sqlist_pkg::STAT_FULL;
          end else if (int'(position) > count) begin
            r.status = sqlist_pkg::STAT_BADPOS;
          end else begin
            for (i = count; i > int'(position); i--) entries[i] = entries[i-1];
            entries[int'(position)] = value;
            count++;
          end
        end
        sqlist_pkg::KIND_DELETE: begin
          // empty check wins over position check
          if (count == 0) begin
            r.status = sqlist_pkg::STAT_EMPTY;
          end else if (int'(position) >= count) begin
            r.status = sqlist_pkg::STAT_BADPOS;
          end else begin
            for (i = int'(position); i + 1 < count; i++) entries[i] = entries[i+1];
            count--;
          end
        end
        default: ;  // unused kind: no change, plain ok
      endcase
      r.element_count = count[sqlist_pkg::ECNT_W-1:0];
      replies_due.push_back(r);
    endfunction

    // compare one accepted reply with the oldest prediction
    function void check_reply(logic [23:0] word);
      list_reply_t exp_r;
      if (replies_due.size() == 0) begin
        $display("%0t: reply expected none, actual %h", $time, word);
        mismatches++;
        return;
      end
      exp_r = replies_due.pop_front();
      if (word[2:0] !== exp_r.status) begin
        $display("%0t: status expected %0d actual %0d", $time, exp_r.status, word[2:0]);
        mismatches++;
      end
      if (word[9:3] !== exp_r.found_index) begin
        $display("%0t: found_index expected %0d actual %0d",
                 $time, exp_r.found_index, word[9:3]);
        mismatches++;
      end
      if (word[17:10] !== exp_r.element_count) begin
        $display("%0t: element_count expected %0d actual %0d",
                 $time, exp_r.element_count, word[17:10]);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [39:0] s_tdata;   // value[31:0], position[39:32]
  logic [1:0]  s_tuser;   // kind[1:0]
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;   // status[2:0], found_index[9:3], element_count[17:10]

  list_tracker #(LIST_DEPTH) tracker;
  bit no_idle;  // stretch with no gaps on either side

  sequential_list_insert_delete_find_top #(
    .CAPACITY(LIST_DEPTH),
    .VALUE_WIDTH(VAL_W)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  // 20 ns clock
  always #10 clk = ~clk;

  // overall time limit
  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

  // send one operation; returns at the edge where it was accepted
  task automatic send_op(logic [1:0] kind, logic [31:0] value, logic [7:0] position);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {position, value};
    s_tuser  <= kind;
    do @(negedge clk); while (!s_tready);
    @(posedge clk);
    tracker.note_op(kind, value, position);
  endtask

  // hold off the sender until every pending reply is back
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (tracker.replies_due.size() != 0) @(posedge clk);
  endtask

  // operand value: small pool for hits and duplicates, extremes, or anything
  function automatic logic [31:0] pick_value();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 32'($signed($urandom_range(0, 15)) - 8);
    if (roll < 70 && tracker.count > 0)
      return tracker.entries[$urandom_range(0, tracker.count - 1)];
    if (roll < 90) return $urandom;
    case ($urandom_range(0, 3))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'h0000_0000;
      default: return 32'hffff_ffff;
    endcase
  endfunction

  // random operations that walk the list from empty to full and back
  task automatic run_random(int n_ops);
    bit          growing;
    int          roll;
    int          k;
    logic [1:0]  kind;
    logic [31:0] value;
    logic [7:0]  position;
    growing = 1'b1;
    for (k = 0; k < n_ops; k++) begin
      if (k % 100 == 0) no_idle = ($urandom_range(0, 3) == 0);
      if (k % 300 == 150) wait_drained();
      if (tracker.count == LIST_DEPTH && $urandom_range(0, 3) == 0) growing = 1'b0;
      if (tracker.count == 0) growing = 1'b1;

      roll = $urandom_range(0, 99);
      if (roll >= 97)     kind = KIND_SPARE;
      else if (roll < 70) kind = growing ? sqlist_pkg::KIND_INSERT : sqlist_pkg::KIND_DELETE;
      else if (roll < 80) kind = growing ? sqlist_pkg::KIND_DELETE : sqlist_pkg::KIND_INSERT;
      else                kind = sqlist_pkg::KIND_FIND;

      value = pick_value();
      if (kind == sqlist_pkg::KIND_DELETE && $urandom_range(0, 1)) value = $urandom;

      // mostly legal positions, some anywhere in the field
      if ($urandom_range(0, 99) < 85) begin
        if (kind == sqlist_pkg::KIND_INSERT)
          position = 8'($urandom_range(0, tracker.count));
        else if (kind == sqlist_pkg::KIND_DELETE && tracker.count > 0)
          position = 8'($urandom_range(0, tracker.count - 1));
        else
          position = 8'($urandom_range(0, 255));
      end else begin
        position = 8'($urandom_range(0, 255));
      end
      send_op(kind, value, position);
    end
  endtask

  // receiver: random stall before each reply
  initial begin
    int stall;
    m_tready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(negedge clk); while (!m_tvalid);
      @(posedge clk);
    end
  end

  // reply monitor: a transaction seen at the falling edge completes at the next rise
  always @(negedge clk) begin
    if (!rst && m_tvalid && m_tready) tracker.check_reply(m_tdata);
  end

  // stimulus and verdict
  initial begin
    tracker  = new();
    no_idle  = 1'b0;
    clk      = 1'b0;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = sqlist_pkg::KIND_FIND;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // empty list corner cases
    send_op(sqlist_pkg::KIND_FIND,   32'h0000_0000, 8'd0);
    send_op(sqlist_pkg::KIND_DELETE, 32'h0000_0000, 8'd0);
    send_op(sqlist_pkg::KIND_INSERT, 32'h0000_0001, 8'd1);
    send_op(sqlist_pkg::KIND_INSERT, 32'h0000_0001, 8'd255);
    send_op(KIND_SPARE,              32'h0000_0000, 8'd0);
    // build a short list with extremes and a duplicate
    send_op(sqlist_pkg::KIND_INSERT, 32'h8000_0000, 8'd0);
    send_op(sqlist_pkg::KIND_INSERT, 32'h7fff_ffff, 8'd1);
    send_op(sqlist_pkg::KIND_INSERT, 32'hffff_ffff, 8'd0);
    send_op(sqlist_pkg::KIND_INSERT, 32'h0000_0000, 8'd3);
    send_op(sqlist_pkg::KIND_INSERT, 32'h7fff_ffff, 8'd4);
    send_op(sqlist_pkg::KIND_INSERT, 32'h1234_5678, 8'd6);
    // finds: hit with duplicate, hit at the head and at index 1, miss
    send_op(sqlist_pkg::KIND_FIND,   32'h7fff_ffff, 8'd255);
    send_op(sqlist_pkg::KIND_FIND,   32'h8000_0000, 8'd0);
    send_op(sqlist_pkg::KIND_FIND,   32'hffff_ffff, 8'd0);
    send_op(sqlist_pkg::KIND_FIND,   32'h0001_2345, 8'd0);
    // deletes: bad positions, head, tail
    send_op(sqlist_pkg::KIND_DELETE, 32'h0000_0000, 8'd5);
    send_op(sqlist_pkg::KIND_DELETE, 32'hffff_ffff, 8'd255);
    send_op(sqlist_pkg::KIND_DELETE, 32'h0000_0000, 8'd0);
    send_op(sqlist_pkg::KIND_DELETE, 32'h0000_0000, 8'd3);
    send_op(KIND_SPARE,              32'hffff_ffff, 8'd255);
    send_op(sqlist_pkg::KIND_FIND,   32'hffff_ffff, 8'd0);
    send_op(sqlist_pkg::KIND_INSERT, 32'h0000_0005, 8'd128);
    wait_drained();

    run_random(900);

    // let the last replies come back, then let the clock run on idle
    wait_drained();
    repeat (8) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.replies_due.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
